// ===== design/crk_pkg.sv =====
// Shared types and constants of the combinatorial rank unranker.
// Holds the sequencer state enum, register indexes and the divider status struct.
// No dependencies.
package crk_pkg;

  localparam int RANK_W     = 64;
  localparam int CNT_W      = 7;
  localparam int SET_W      = 4;
  localparam int ITEM_W     = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam int DEF_MAX_SET_SIZE = 10;
  localparam int DEF_MAX_ITEMS    = 64;

  localparam logic [RANK_W-1:0] SAT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_SIZE     = 8'd0,
    REG_ITEM_COUNT   = 8'd1,
    REG_COMB_MODE    = 8'd2,
    REG_WITH_REPEATS = 8'd3
  } crk_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BIN_START,
    S_BIN_STEP,
    S_BIN_MULW,
    S_BIN_DIVW,
    S_PROD_START,
    S_PROD_STEP,
    S_PROD_MULW,
    S_RET,
    S_SLOT,
    S_CMP,
    S_PDIV_W,
    S_SCAN,
    S_EMIT,
    S_ERR
  } crk_state_t;

  typedef enum logic [1:0] {
    RET_TOTAL,
    RET_BLOCK_C,
    RET_BLOCK_P
  } crk_ret_t;

  typedef struct packed {
    logic busy;
    logic done;
  } crk_div_stat_t;

endpackage

// ===== design/crk_satmul.sv =====
// Registered saturating multiplier: 64-bit operand by 7-bit factor.
// Depends on crk_pkg.
module crk_satmul (
  input  logic                       clk,
  input  logic [crk_pkg::RANK_W-1:0] a,
  input  logic [crk_pkg::CNT_W-1:0]  b,
  output logic [crk_pkg::RANK_W-1:0] p_r
);
  import crk_pkg::*;

  logic [RANK_W+CNT_W-1:0] full;
  logic [RANK_W-1:0]       p_nxt;

  assign full  = a * b;
  // clamp on any overflow
  assign p_nxt = (|full[RANK_W+CNT_W-1:RANK_W]) ? SAT_MAX : full[RANK_W-1:0];

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== design/crk_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit by 64-bit.
// Depends on crk_pkg.
module crk_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [crk_pkg::RANK_W-1:0] dividend,
  input  logic [crk_pkg::RANK_W-1:0] divisor,
  output logic [crk_pkg::RANK_W-1:0] quot,
  output logic [crk_pkg::RANK_W-1:0] rem,
  output crk_pkg::crk_div_stat_t     stat
);
  import crk_pkg::*;

  localparam int STEP_W = $clog2(RANK_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [RANK_W-1:0] q_r, q_nxt;
  logic [RANK_W-1:0] r_r, r_nxt;
  logic [RANK_W-1:0] d_r, d_nxt;
  logic [RANK_W:0]   sh;
  logic [RANK_W:0]   diff;
  logic              ge;

  assign sh   = {r_r, q_r[RANK_W-1]};
  assign ge   = sh >= {1'b0, d_r};
  assign diff = sh - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      r_nxt   = ge ? diff[RANK_W-1:0] : sh[RANK_W-1:0];
      q_nxt   = {q_r[RANK_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(RANK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign quot      = q_r;
  assign rem       = r_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== design/combinatorial_rank_unranker_core.sv =====
// Top level of the combinatorial rank unranker: sequencer, registers, output stage.
// Depends on crk_pkg, crk_satmul and crk_div.
//
// Usage:
//   Input channel in_valid / in_stall / in_rank: one 64-bit rank per item.
//   Result channel out_valid / out_stall with out_slot, out_item_index, out_last,
//   out_out_of_range: set_size results per rank (slot 0 first, last flagged),
//   or one flagged error result for a bad configuration or a rank not below the total.
//   Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data; write it
//   only while idle. cfg_ready is always high; unknown indexes are dropped.
// Timing:
//   One rank at a time; in_stall stays high until its last result is loaded,
//   and the next rank can be taken the cycle after. Counts use a shared
//   saturating multiplier and a shared restoring divider. A combination slot
//   walks up to item_count candidates, one binomial each. A permutation-with-repeats
//   slot is one division; a permutation-without-repeats slot is k-1-slot
//   factors, one division and a scan of the used mask, one item per cycle.
// Reset: synchronous, active low; returns to idle with set_size 1,
//   item_count 1, combination mode, no repeats, and no pending result.
// Stall: a stalled result holds in the output register; the sequencer waits
//   to load the next one until the register drains.
module combinatorial_rank_unranker_core #(
  parameter int MAX_SET_SIZE = crk_pkg::DEF_MAX_SET_SIZE,
  parameter int MAX_ITEMS    = crk_pkg::DEF_MAX_ITEMS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crk_pkg::RANK_W-1:0]     in_rank,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [crk_pkg::SET_W-1:0]      out_slot,
  output logic [crk_pkg::ITEM_W-1:0]     out_item_index,
  output logic                           out_last,
  output logic                           out_out_of_range,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crk_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crk_pkg::*;

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  // configuration
  logic [SET_W-1:0] set_size_r;
  logic [CNT_W-1:0] item_count_r;
  logic             comb_mode_r;
  logic             with_rep_r;

  // sequencer state
  crk_state_t state_r, state_nxt;
  crk_ret_t   ret_r, ret_nxt;

  logic [RANK_W-1:0]    rem_r, rem_nxt;
  logic [RANK_W-1:0]    acc_r, acc_nxt;
  logic [RANK_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]     bn_r, bn_nxt;
  logic [CNT_W-1:0]     br_r, br_nxt;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic [CNT_W-1:0]     pa_r, pa_nxt;
  logic [CNT_W-1:0]     pcnt_r, pcnt_nxt;
  logic                 pdec_r, pdec_nxt;
  logic [SET_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]     v_r, v_nxt;
  logic [MAX_ITEMS-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]     scan_j_r, scan_j_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [SET_W-1:0]  out_slot_r, out_slot_nxt;
  logic [ITEM_W-1:0] out_item_r, out_item_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;

  // shared units
  logic [RANK_W-1:0] mul_p;
  logic [CNT_W-1:0]  mul_b;
  logic              div_start;
  logic [RANK_W-1:0] div_a, div_b, div_q, div_r;
  crk_div_stat_t     div_stat;

  // helpers
  logic [CNT_W-1:0] kx, m, km1s;
  logic             bad_cfg, out_free, last_slot, used_bit, scan_end, scan_hit, cmp_stop;

  assign kx        = CNT_W'(set_size_r);
  assign m         = item_count_r;
  assign km1s      = kx - 1'b1 - CNT_W'(slot_r);
  assign bad_cfg   = (set_size_r == '0) || (kx > CNT_W'(MAX_SET_SIZE)) ||
                     (m == '0) || (m > CNT_W'(MAX_ITEMS));
  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = (CNT_W'(slot_r) + 1'b1) == kx;
  assign used_bit  = used_r[scan_j_r];
  assign scan_end  = (CNT_W'(scan_j_r) + 1'b1) == m;
  assign scan_hit  = !used_bit && (RANK_W'(scan_cnt_r) == idx_r);
  assign cmp_stop  = ((v_r + 1'b1) >= m) || (rem_r < acc_r);

  assign mul_b = (state_r == S_BIN_STEP) ? (bn_r - br_r + j_r)
                                         : (pa_r - (pdec_r ? j_r : '0));

  crk_satmul u_mul (
    .clk (clk),
    .a   (acc_r),
    .b   (mul_b),
    .p_r (mul_p)
  );

  crk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (div_q),
    .rem      (div_r),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (bad_cfg) state_nxt = S_ERR;
          else if (comb_mode_r) state_nxt = S_BIN_START;
          else state_nxt = S_PROD_START;
        end
      end
      S_BIN_START:  state_nxt = (br_r > bn_r) ? S_RET : S_BIN_STEP;
      S_BIN_STEP:   state_nxt = (j_r > br_r) ? S_RET : S_BIN_MULW;
      S_BIN_MULW:   state_nxt = (mul_p == SAT_MAX) ? S_RET : S_BIN_DIVW;
      S_BIN_DIVW: begin
        if (div_stat.done) state_nxt = S_BIN_STEP;
      end
      S_PROD_START: state_nxt = (pdec_r && (pcnt_r > pa_r)) ? S_RET : S_PROD_STEP;
      S_PROD_STEP:  state_nxt = (j_r == pcnt_r) ? S_RET : S_PROD_MULW;
      S_PROD_MULW:  state_nxt = S_PROD_STEP;
      S_RET: begin
        case (ret_r)
          RET_TOTAL:   state_nxt = (rem_r >= acc_r) ? S_ERR : S_SLOT;
          RET_BLOCK_C: state_nxt = S_CMP;
          RET_BLOCK_P: state_nxt = S_PDIV_W;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_SLOT: begin
        if (comb_mode_r) begin
          state_nxt = (!with_rep_r && ((v_r + 1'b1) > m)) ? S_CMP : S_BIN_START;
        end else begin
          state_nxt = with_rep_r ? S_PDIV_W : S_PROD_START;
        end
      end
      S_CMP:    state_nxt = cmp_stop ? S_EMIT : S_SLOT;
      S_PDIV_W: begin
        if (div_stat.done) state_nxt = with_rep_r ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        if (scan_hit || scan_end) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = last_slot ? S_IDLE : S_SLOT;
      end
      S_ERR: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    ret_nxt       = ret_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    bn_nxt        = bn_r;
    br_nxt        = br_r;
    j_nxt         = j_r;
    pa_nxt        = pa_r;
    pcnt_nxt      = pcnt_r;
    pdec_nxt      = pdec_r;
    slot_nxt      = slot_r;
    v_nxt         = v_r;
    used_nxt      = used_r;
    scan_j_nxt    = scan_j_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_slot_nxt  = out_slot_r;
    out_item_nxt  = out_item_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    div_a         = rem_r;
    div_b         = RANK_W'(m);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rem_nxt  = in_rank;
          slot_nxt = '0;
          v_nxt    = '0;
          used_nxt = '0;
          ret_nxt  = RET_TOTAL;
          bn_nxt   = with_rep_r ? (m + kx - 1'b1) : m;
          br_nxt   = kx;
          pa_nxt   = m;
          pcnt_nxt = kx;
          pdec_nxt = !with_rep_r;
        end
      end
      S_BIN_START: begin
        acc_nxt = (br_r > bn_r) ? '0 : RANK_W'(1);
        j_nxt   = CNT_W'(1);
      end
      S_BIN_MULW: begin
        if (mul_p == SAT_MAX) begin
          acc_nxt = SAT_MAX;
        end else begin
          div_start = 1'b1;
          div_a     = mul_p;
          div_b     = RANK_W'(j_r);
        end
      end
      S_BIN_DIVW: begin
        if (div_stat.done) begin
          acc_nxt = div_q;
          j_nxt   = j_r + 1'b1;
        end
      end
      S_PROD_START: begin
        acc_nxt = (pdec_r && (pcnt_r > pa_r)) ? '0 : RANK_W'(1);
        j_nxt   = '0;
      end
      S_PROD_MULW: begin
        acc_nxt = mul_p;
        j_nxt   = j_r + 1'b1;
      end
      S_RET: begin
        if (ret_r == RET_BLOCK_P) begin
          div_start = 1'b1;
          div_a     = rem_r;
          div_b     = (acc_r == '0) ? RANK_W'(1) : acc_r;
        end
      end
      S_SLOT: begin
        if (comb_mode_r) begin
          ret_nxt = RET_BLOCK_C;
          br_nxt  = km1s;
          if (with_rep_r) begin
            bn_nxt = (m - v_r) + km1s - 1'b1;
          end else if ((v_r + 1'b1) <= m) begin
            bn_nxt = m - 1'b1 - v_r;
          end else begin
            acc_nxt = '0;
          end
        end else if (with_rep_r) begin
          div_start = 1'b1;
          div_a     = rem_r;
          div_b     = RANK_W'(m);
        end else begin
          ret_nxt  = RET_BLOCK_P;
          pa_nxt   = m - 1'b1 - CNT_W'(slot_r);
          pcnt_nxt = km1s;
          pdec_nxt = 1'b1;
        end
      end
      S_CMP: begin
        if (!cmp_stop) begin
          rem_nxt = rem_r - acc_r;
          v_nxt   = v_r + 1'b1;
        end
      end
      S_PDIV_W: begin
        if (div_stat.done) begin
          if (with_rep_r) begin
            v_nxt   = div_r[CNT_W-1:0];
            rem_nxt = div_q;
          end else begin
            idx_nxt      = div_q;
            rem_nxt      = div_r;
            scan_j_nxt   = '0;
            scan_cnt_nxt = '0;
            v_nxt        = '0;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          v_nxt              = CNT_W'(scan_j_r);
          used_nxt[scan_j_r] = 1'b1;
        end else begin
          if (!used_bit) scan_cnt_nxt = scan_cnt_r + 1'b1;
          if (!scan_end) scan_j_nxt = scan_j_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = slot_r;
          out_item_nxt  = v_r[ITEM_W-1:0];
          out_last_nxt  = last_slot;
          out_err_nxt   = 1'b0;
          slot_nxt      = slot_r + 1'b1;
          // next ascending set starts past this item, a multiset at it
          if (comb_mode_r && !with_rep_r) v_nxt = v_r + 1'b1;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = '0;
          out_item_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      set_size_r   <= SET_W'(1);
      item_count_r <= CNT_W'(1);
      comb_mode_r  <= 1'b1;
      with_rep_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SET_SIZE:     set_size_r   <= cfg_data[SET_W-1:0];
          REG_ITEM_COUNT:   item_count_r <= cfg_data[CNT_W-1:0];
          REG_COMB_MODE:    comb_mode_r  <= cfg_data[0];
          REG_WITH_REPEATS: with_rep_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
    ret_r      <= ret_nxt;
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    idx_r      <= idx_nxt;
    bn_r       <= bn_nxt;
    br_r       <= br_nxt;
    j_r        <= j_nxt;
    pa_r       <= pa_nxt;
    pcnt_r     <= pcnt_nxt;
    pdec_r     <= pdec_nxt;
    slot_r     <= slot_nxt;
    v_r        <= v_nxt;
    used_r     <= used_nxt;
    scan_j_r   <= scan_j_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    out_slot_r <= out_slot_nxt;
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_slot         = out_slot_r;
  assign out_item_index   = out_item_r;
  assign out_last         = out_last_r;
  assign out_out_of_range = out_err_r;

`ifndef SYNTH
  a_err_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_last && out_slot == '0 && out_item_index == '0))
    else $error("error result not a single cleared item");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the rank finished");

  a_div_idle_start : assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== tb/combinatorial_rank_unranker_core_tb.sv =====
// Testbench for combinatorial_rank_unranker_core: drives ranks and register
// writes, predicts every slot item in a scoreboard class and checks them in order.
// Depends on crk_pkg and the core RTL.
`timescale 1ns / 1ps

module combinatorial_rank_unranker_core_tb;
  import crk_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
  localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 100_000_000;
  localparam int DRAIN_CYCLES = 40;

  // One expected slot item.
  typedef struct packed {
    logic [SET_W-1:0]  slot;
    logic [ITEM_W-1:0] item_index;
    logic              last;
    logic              out_of_range;
  } slot_item_t;

  // Scoreboard: shadow registers, the unranking predictor, and the queue of
  // slot items still owed by the block.
  class unrank_board;
    logic [3:0] set_size = 4'd1;
    logic [6:0] item_count = 7'd1;
    logic       comb_mode = 1'b1;
    logic       with_rep = 1'b0;
    slot_item_t owed[$];
    int         errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SET_SIZE:     set_size = val[3:0];
        REG_ITEM_COUNT:   item_count = val[6:0];
        REG_COMB_MODE:    comb_mode = val[0];
        REG_WITH_REPEATS: with_rep = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned sat_mul(longint unsigned a, longint unsigned b);
      if (a != 0 && b > ALL_ONES / a) return ALL_ONES;
      return a * b;
    endfunction

    function longint unsigned choose(longint unsigned n, longint unsigned r);
      longint unsigned res, t;
      res = 1;
      if (r > n) return 0;
      for (longint unsigned j = 1; j <= r; j++) begin
        t = sat_mul(res, n - r + j);
        if (t == ALL_ONES) return ALL_ONES;
        res = t / j;
      end
      return res;
    endfunction

    function longint unsigned falling(longint unsigned a, longint unsigned cnt);
      longint unsigned res;
      res = 1;
      if (cnt > a) return 0;
      for (longint unsigned j = 0; j < cnt; j++) res = sat_mul(res, a - j);
      return res;
    endfunction

    function longint unsigned set_total();
      longint unsigned k, m, res;
      k = set_size;
      m = item_count;
      res = 1;
      if (comb_mode) return with_rep ? choose(m + k - 1, k) : choose(m, k);
      if (with_rep) begin
        for (longint unsigned j = 0; j < k; j++) res = sat_mul(res, m);
        return res;
      end
      return falling(m, k);
    endfunction

    // Work out every slot item for an accepted rank.
    function void note_rank(longint unsigned rank);
      longint unsigned k, m, rem, v, prev, blk, idx, cnt, used;
      slot_item_t e;
      k = set_size;
      m = item_count;
      if (k == 0 || k > DEF_MAX_SET_SIZE || m == 0 || m > DEF_MAX_ITEMS ||
          rank >= set_total()) begin
        e = '{slot: '0, item_index: '0, last: 1'b1, out_of_range: 1'b1};
        owed.push_back(e);
        return;
      end
      rem = rank;
      used = 0;
      prev = 0;
      for (longint unsigned s = 0; s < k; s++) begin
        v = 0;
        if (comb_mode && with_rep) begin
          v = (s == 0) ? 0 : prev;
          forever begin
            blk = choose((m - v) + (k - 1 - s) - 1, k - 1 - s);
            if (v + 1 >= m || rem < blk) break;
            rem -= blk;
            v++;
          end
        end else if (comb_mode) begin
          v = (s == 0) ? 0 : prev + 1;
          forever begin
            blk = (v + 1 <= m) ? choose(m - 1 - v, k - 1 - s) : 0;
            if (v + 1 >= m || rem < blk) break;
            rem -= blk;
            v++;
          end
        end else if (with_rep) begin
          v = rem % m;
          rem = rem / m;
        end else begin
          blk = falling(m - 1 - s, k - 1 - s);
          if (blk == 0) blk = 1;
          idx = rem / blk;
          rem = rem % blk;
          cnt = 0;
          for (longint unsigned j = 0; j < m; j++) begin
            if (used[j] == 1'b0) begin
              if (cnt == idx) begin
                v = j;
                used[j] = 1'b1;
                break;
              end
              cnt++;
            end
          end
        end
        prev = v & 64'h3F;
        e.slot = s[SET_W-1:0];
        e.item_index = v[ITEM_W-1:0];
        e.last = (s + 1 == k);
        e.out_of_range = 1'b0;
        owed.push_back(e);
      end
    endfunction

    function void check_result(slot_item_t got);
      slot_item_t want;
      if (owed.size() == 0) begin
        $error("unexpected result item: slot %0d item_index %0d", got.slot,
               got.item_index);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
        errors++;
      end
      if (got.item_index !== want.item_index) begin
        $error("item_index: expected %0d, actual %0d", want.item_index, got.item_index);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %0d, actual %0d", want.out_of_range,
               got.out_of_range);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [RANK_W-1:0]     in_rank;
  logic                  out_valid;
  logic                  out_stall;
  logic [SET_W-1:0]      out_slot;
  logic [ITEM_W-1:0]     out_item_index;
  logic                  out_last;
  logic                  out_out_of_range;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  unrank_board board = new();
  bit          quiet;    // no idling on either side while set
  int          cycles;

  combinatorial_rank_unranker_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: the run ends here if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("combinatorial_rank_unranker_core_tb NOT OK");
      $finish;
    end
  end

  // Result side: check every accepted item, then draw a fresh stall length.
  initial begin
    int hold;
    hold = 0;
    out_stall <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_result('{slot: out_slot, item_index: out_item_index,
                             last: out_last, out_of_range: out_out_of_range});
        hold = quiet ? 0 : $urandom_range(0, 13);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  // Write one register; the block must be idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, val);
  endtask

  // Drop valid and wait until every owed item has come out, plus slack.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int k, int m, bit comb, bit rep);
    drain();
    write_reg(REG_SET_SIZE, k[7:0]);
    write_reg(REG_ITEM_COUNT, m[7:0]);
    write_reg(REG_COMB_MODE, {7'd0, comb});
    write_reg(REG_WITH_REPEATS, {7'd0, rep});
  endtask

  // Present one rank and hold it until the block takes it.
  task automatic send_rank(longint unsigned rank);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rank  <= rank;
    do @(posedge clk); while (in_stall);
    board.note_rank(rank);
  endtask

  // Pick a rank: mostly valid ones, some at the edge, some raw 64-bit noise.
  function automatic longint unsigned pick_rank();
    longint unsigned tot;
    int sel;
    tot = board.set_total();
    sel = $urandom_range(0, 99);
    if (sel < 12 || tot == 0) return {$urandom, $urandom};
    if (sel < 20) return tot - 1;
    if (sel < 25) return tot;
    return {$urandom, $urandom} % tot;
  endfunction

  initial begin
    longint unsigned tot;
    in_valid  <= 1'b0;
    in_rank   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    cycles    <= 0;
    quiet     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: a single item out of one.
    send_rank(0);
    send_rank(1);
    send_rank(ALL_ONES);

    // Every mode at a small size: first, last, one past the end, all ones.
    for (int md = 0; md < 4; md++) begin
      configure(3, 5, md[1], md[0]);
      tot = board.set_total();
      send_rank(0);
      send_rank(tot - 1);
      send_rank(tot);
      send_rank(ALL_ONES);
    end

    // Illegal sizes, k above m without repeats, and a dropped register index.
    configure(0, 5, 1'b1, 1'b0);
    send_rank(0);
    configure(15, 5, 1'b0, 1'b1);
    send_rank(0);
    configure(2, 0, 1'b0, 1'b1);
    send_rank(0);
    configure(2, 127, 1'b1, 1'b1);
    send_rank(0);
    configure(4, 3, 1'b1, 1'b0);
    send_rank(0);
    drain();
    write_reg(REG_UNUSED, 8'hFF);
    send_rank(0);

    // Largest legal sizes, a few items per mode.
    for (int md = 0; md < 4; md++) begin
      configure(10, 64, md[1], md[0]);
      tot = board.set_total();
      send_rank(tot - 1);
      send_rank({$urandom, $urandom} % tot);
      send_rank({$urandom, $urandom});
    end
    configure(1, 64, 1'b0, 1'b0);
    send_rank(63);
    send_rank(64);

    // Random phases, mostly small sizes to keep the walk short.
    for (int ph = 0; ph < 22; ph++) begin
      if ($urandom_range(0, 9) == 0)
        configure($urandom_range(0, 15), $urandom_range(0, 80), 1'($urandom),
                  1'($urandom));
      else
        configure($urandom_range(1, 4), $urandom_range(1, 12), 1'($urandom),
                  1'($urandom));
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 15; i++) begin
        // Hold off the sender once until the block has emptied out.
        if (ph == 5 && i == 7) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (board.owed.size() != 0) @(posedge clk);
        end
        send_rank(pick_rank());
      end
    end

    drain();
    if (board.errors == 0)
      $display("combinatorial_rank_unranker_core_tb OK");
    else
      $display("combinatorial_rank_unranker_core_tb NOT OK");
    $finish;
  end

endmodule
